/* rtl/ssr_pkg.sv */
// Shared types, field widths and default sizes for the sprite slot refill block.
package ssr_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned SlotCountDef      = 16;
  localparam int unsigned TableEntriesDef   = 256;
  localparam int unsigned ScreenWidthDef    = 320;
  localparam int unsigned ScreenHeightDef   = 240;
  localparam int unsigned SpriteSpanDef     = 16;
  localparam int unsigned PriorityLevelsDef = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned ActionW  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_WRITE = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_LINE  = 2'd2
  } action_e;

  // One sprite attribute table entry as stored.
  typedef struct packed {
    logic signed [10:0] x;
    logic signed [9:0]  y;
    logic [3:0]         prio;
    logic [1:0]         mirror;
    logic               opaque;
    logic [9:0]         image;
    logic [2:0]         height_code;
    logic [2:0]         palette;
  } tbl_entry_t;

  // One active slot as stored.
  typedef struct packed {
    logic signed [10:0] x;
    logic signed [9:0]  y;
    logic [3:0]         prio;
    logic [6:0]         height;
    logic [9:0]         image;
    logic [1:0]         mirror;
    logic [2:0]         palette;
    logic               opaque;
  } slot_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       tbl_write;
    logic       frame_clear;
    logic       line_load;
    logic       rf_read;
    logic       rf_check;
    logic       em_read;
    logic       em_load;
    logic       last;
    logic [3:0] prio;
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;
    logic prio_match;
    logic prio_present;
  } dp_sts_t;

endpackage

/* rtl/ssr_datapath.sv */
// Datapath: attribute table, slot store, refill decision and the result register.
module ssr_datapath #(
  parameter int unsigned SLOT_COUNT      = 16,
  parameter int unsigned TABLE_ENTRIES   = 256,
  parameter int unsigned SCREEN_WIDTH    = 320,
  parameter int unsigned SCREEN_HEIGHT   = 240,
  parameter int unsigned SPRITE_SPAN     = 16,
  parameter int unsigned PRIORITY_LEVELS = 16,
  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssr_pkg::ctrl_cmd_t            cmd_i,
  input  logic [SlotW-1:0]              slot_idx_i,
  output ssr_pkg::dp_sts_t              sts_o,
  input  logic [ssr_pkg::InDataW-1:0]   in_data_i,
  output logic [ssr_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_valid_o,
  output logic                          out_last_o,
  input  logic                          out_ready_i
);
  import ssr_pkg::*;

  localparam int unsigned TabW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned NeW  = $clog2(TABLE_ENTRIES + 1);
  localparam logic signed [11:0] XLow  = 12'(-SPRITE_SPAN);
  localparam logic signed [11:0] XHigh = 12'(SCREEN_WIDTH);
  localparam logic [9:0]         YGone = 10'(SCREEN_HEIGHT);

  // Input field decode.
  logic [7:0]       wr_idx;
  logic [8:0]       line_in;
  tbl_entry_t       wr_entry;
  logic [3:0]       wr_pri;
  logic             wr_ok;
  logic [TabW+7:0]  wr_addr_ext;

  assign wr_idx  = in_data_i[7:0];
  assign line_in = in_data_i[60:52];
  assign wr_pri  = in_data_i[32:29];
  assign wr_ok   = {3'b000, wr_idx} < 11'(TABLE_ENTRIES);
  assign wr_addr_ext = {{TabW{1'b0}}, wr_idx};

  always_comb begin
    wr_entry.x           = in_data_i[18:8];
    wr_entry.y           = in_data_i[28:19];
    wr_entry.prio        = ({1'b0, wr_pri} >= 5'(PRIORITY_LEVELS)) ?
                           4'(PRIORITY_LEVELS - 1) : wr_pri;
    wr_entry.mirror      = in_data_i[34:33];
    wr_entry.opaque      = in_data_i[35];
    wr_entry.image       = in_data_i[45:36];
    wr_entry.height_code = in_data_i[48:46];
    wr_entry.palette     = in_data_i[51:49];
  end

  // Attribute table; contents are undefined until written.
  tbl_entry_t tbl_mem [TABLE_ENTRIES];
  tbl_entry_t tbl_rd_q;
  logic [NeW-1:0] next_entry_q, next_entry_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_write && wr_ok) begin
      tbl_mem[wr_addr_ext[TabW-1:0]] <= wr_entry;
    end
    if (cmd_i.rf_read) begin
      tbl_rd_q <= tbl_mem[next_entry_q[TabW-1:0]];
    end
  end

  // Slot store, with a valid bit per slot so that a cleared slot reads as zero.
  slot_t            slot_mem [SLOT_COUNT];
  slot_t            slot_rd_q;
  logic             rd_vld_q;
  logic [SLOT_COUNT-1:0] slot_vld_q;
  logic [3:0]       prio_q [SLOT_COUNT];
  logic [8:0]       line_q;

  slot_t            cur;
  slot_t            new_slot;
  logic             refill;
  logic             has_entry;
  logic             off_screen;
  logic signed [11:0] line_s, end_s, x_s;

  assign cur       = rd_vld_q ? slot_rd_q : '0;
  assign line_s    = $signed({3'b000, line_q});
  assign end_s     = $signed({cur.y[9], cur.y[9], cur.y}) + $signed({5'b00000, cur.height});
  assign refill    = line_s >= end_s;
  assign has_entry = next_entry_q < NeW'(TABLE_ENTRIES);
  assign x_s       = $signed({tbl_rd_q.x[10], tbl_rd_q.x});
  assign off_screen = (x_s <= XLow) || (x_s >= XHigh);

  always_comb begin
    new_slot = cur;
    if (has_entry) begin
      new_slot.x        = tbl_rd_q.x;
      new_slot.y        = tbl_rd_q.y;
      new_slot.prio     = tbl_rd_q.prio;
      new_slot.height   = {({1'b0, tbl_rd_q.height_code} + 4'd1), 3'b000};
      new_slot.image    = tbl_rd_q.image;
      new_slot.mirror   = tbl_rd_q.mirror;
      new_slot.palette  = tbl_rd_q.palette;
      new_slot.opaque   = tbl_rd_q.opaque;
    end
    if (!has_entry || off_screen) begin
      new_slot.y      = YGone;
      new_slot.height = 7'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_check && refill) begin
      slot_mem[slot_idx_i] <= new_slot;
    end
    if (cmd_i.rf_read || cmd_i.em_read) begin
      slot_rd_q <= slot_mem[slot_idx_i];
    end
    if (cmd_i.line_load) begin
      line_q <= line_in;
    end
  end

  assign next_entry_d = next_entry_q + NeW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_entry_q <= '0;
      slot_vld_q   <= '0;
      rd_vld_q     <= 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        prio_q[k] <= '0;
      end
    end else begin
      if (cmd_i.rf_read || cmd_i.em_read) begin
        rd_vld_q <= slot_vld_q[slot_idx_i];
      end
      if (cmd_i.frame_clear) begin
        next_entry_q <= '0;
        slot_vld_q   <= '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          prio_q[k] <= '0;
        end
      end else if (cmd_i.rf_check && refill) begin
        slot_vld_q[slot_idx_i] <= 1'b1;
        prio_q[slot_idx_i]     <= new_slot.prio;
        if (has_entry) begin
          next_entry_q <= next_entry_d;
        end
      end
    end
  end

  // Result register.
  slot_t      out_slot_q;
  logic [3:0] out_num_q;
  logic       out_valid_q, out_last_q;
  logic [SlotW+3:0] num_ext;

  assign num_ext = {4'b0000, slot_idx_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_load) begin
      out_slot_q <= cur;
      out_num_q  <= num_ext[3:0];
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.em_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {4'b0000, out_slot_q.opaque, out_slot_q.palette, out_slot_q.mirror,
                        out_slot_q.image, out_slot_q.height, out_slot_q.prio,
                        out_slot_q.y, out_slot_q.x, out_num_q};

  // Status for the emission walk.
  always_comb begin
    sts_o.out_free     = !out_valid_q || out_ready_i;
    sts_o.prio_match   = prio_q[slot_idx_i] == cmd_i.prio;
    sts_o.prio_present = 1'b0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (prio_q[k] == cmd_i.prio) begin
        sts_o.prio_present = 1'b1;
      end
    end
  end

endmodule

/* rtl/ssr_ctrl.sv */
// Sequencer: decodes items and walks the slots for refill and for priority-ordered emission.
module ssr_ctrl #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [ssr_pkg::ActionW-1:0]         in_action_i,
  output logic                                in_ready_o,
  output ssr_pkg::ctrl_cmd_t                  cmd_o,
  output logic [SlotW-1:0]                    slot_idx_o,
  input  ssr_pkg::dp_sts_t                    sts_i
);
  import ssr_pkg::*;

  localparam logic [SlotW-1:0] IdxLast = SlotW'(SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RF_RD   = 5'b00010,
    ST_RF_CHK  = 5'b00100,
    ST_EM_SCAN = 5'b01000,
    ST_EM_OUT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic [3:0]       pri_q, pri_d;
  logic [SlotW-1:0] step_idx;
  logic [3:0]       step_pri;
  action_e          action;

  assign action     = action_e'(in_action_i);
  assign in_ready_o = state_q == ST_IDLE;
  assign slot_idx_o = idx_q;

  // Emission order: descending slot index inside a priority, then the next priority.
  always_comb begin
    if (idx_q == '0) begin
      step_idx = IdxLast;
      step_pri = pri_q + 4'd1;
    end else begin
      step_idx = idx_q - SlotW'(1);
      step_pri = pri_q;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    pri_d   = pri_q;
    cmd_o   = '0;
    cmd_o.prio = pri_q;
    cmd_o.last = cnt_q == IdxLast;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action)
            ACT_WRITE: cmd_o.tbl_write = 1'b1;
            ACT_FRAME: cmd_o.frame_clear = 1'b1;
            ACT_LINE: begin
              cmd_o.line_load = 1'b1;
              idx_d   = '0;
              state_d = ST_RF_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RF_RD: begin
        cmd_o.rf_read = 1'b1;
        state_d = ST_RF_CHK;
      end
      ST_RF_CHK: begin
        cmd_o.rf_check = 1'b1;
        if (idx_q == IdxLast) begin
          pri_d   = '0;
          cnt_d   = '0;
          state_d = ST_EM_SCAN;
        end else begin
          idx_d   = idx_q + SlotW'(1);
          state_d = ST_RF_RD;
        end
      end
      ST_EM_SCAN: begin
        if (!sts_i.prio_present) begin
          pri_d = pri_q + 4'd1;
          idx_d = IdxLast;
        end else if (sts_i.prio_match) begin
          if (sts_i.out_free) begin
            cmd_o.em_read = 1'b1;
            state_d = ST_EM_OUT;
          end
        end else begin
          idx_d = step_idx;
          pri_d = step_pri;
        end
      end
      ST_EM_OUT: begin
        cmd_o.em_load = 1'b1;
        cnt_d = cnt_q + SlotW'(1);
        if (cnt_q == IdxLast) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = step_idx;
          pri_d   = step_pri;
          state_d = ST_EM_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      pri_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      pri_q   <= pri_d;
    end
  end

  // A result is only loaded when the result register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.em_load |-> sts_i.out_free)
    else $error("result loaded over an unread result");

  // The slot walk never leaves the slot range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < (SlotW + 1)'(SLOT_COUNT))
    else $error("slot index out of range");

  // After the final slot of a line is emitted the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_OUT && cnt_q == IdxLast) |=> state_q == ST_IDLE)
    else $error("emission did not end after the last slot");

endmodule

/* rtl/sprite_slot_refill.sv */
// Top level of the sprite slot refill block: sequencer plus datapath.
//
// Items arrive on the s_axis channel; tuser carries the action (write table
// entry, begin frame, advance to line) and tdata the entry and line fields.
// A write item or a begin-frame item produces no result. An advance item
// first visits every slot in ascending order, each in a read step (slot
// store and table read) and then a check step (the refill decision and
// write back). The emission walk then visits the slots once per priority
// that is in use, one slot per cycle unless a matching slot waits on the
// result register, passes over each empty priority below the highest one in
// use without visiting its slots and spends an extra output step on each
// result. Exactly SLOT_COUNT results leave on the m_axis channel per line,
// the final one with tlast. The input side is ready only while no line is
// being processed; the last result of a line may still sit in the output
// register when the next item is taken. When the receiver stalls, the
// emission walk waits on the held result. Reset empties all slots and
// rewinds the table pointer; table entries are undefined until written.
module sprite_slot_refill #(
  parameter int unsigned SLOT_COUNT      = ssr_pkg::SlotCountDef,
  parameter int unsigned TABLE_ENTRIES   = ssr_pkg::TableEntriesDef,
  parameter int unsigned SCREEN_WIDTH    = ssr_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT   = ssr_pkg::ScreenHeightDef,
  parameter int unsigned SPRITE_SPAN     = ssr_pkg::SpriteSpanDef,
  parameter int unsigned PRIORITY_LEVELS = ssr_pkg::PriorityLevelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index[7:0], sprite_x[18:8], sprite_y[28:19], sprite_priority[32:29],
  // sprite_mirror[34:33], sprite_opaque[35], sprite_image[45:36],
  // sprite_height_code[48:46], sprite_palette[51:49], line_number[60:52]
  input  logic [ssr_pkg::InDataW-1:0]      s_axis_tdata,
  // action[1:0]
  input  logic [ssr_pkg::ActionW-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_number[3:0], slot_x[14:4], slot_y[24:15], slot_priority[28:25],
  // slot_height[35:29], slot_image[45:36], slot_mirror[47:46],
  // slot_palette[50:48], slot_opaque[51]
  output logic [ssr_pkg::OutDataW-1:0]     m_axis_tdata,
  // last
  output logic                             m_axis_tlast
);
  import ssr_pkg::*;

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [SlotW-1:0] slot_idx;

  // The sequencer owns all ordering; the datapath only reacts to its commands.
  ssr_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .slot_idx_o  (slot_idx),
    .sts_i       (sts)
  );

  ssr_datapath #(
    .SLOT_COUNT      (SLOT_COUNT),
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .SPRITE_SPAN     (SPRITE_SPAN),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .slot_idx_i  (slot_idx),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

/* tb/sv/sprite_slot_refill_test.sv */
// Self-checking stream testbench for the sprite slot refill block.
module sprite_slot_refill_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int unsigned SLOTS       = SlotCountDef;
  localparam int unsigned ENTRIES     = TableEntriesDef;
  localparam int unsigned SCR_W       = ScreenWidthDef;
  localparam int unsigned SCR_H       = ScreenHeightDef;
  localparam int unsigned SPAN        = SpriteSpanDef;
  localparam int unsigned PRIO_LEVELS = PriorityLevelsDef;

  // The one action code that the block must ignore.
  localparam logic [ActionW-1:0] ACT_SPARE = 2'd3;

  // Items that follow the last expected result can still be in flight, and a
  // stray result needs time to show up, so the run idles this long at the end.
  localparam int unsigned DRAIN_CYCLES = 200;

  // Receiver hold-off that backs the block up into its input side.
  localparam int unsigned HOLD_AFTER   = 100;
  localparam int unsigned HOLD_CYCLES  = 600;

  // Input item as it sits on s_axis_tdata, highest field first.
  typedef struct packed {
    logic [2:0]         pad;
    logic [8:0]         line;
    logic [2:0]         palette;
    logic [2:0]         hcode;
    logic [9:0]         image;
    logic               opaque;
    logic [1:0]         mirror;
    logic [3:0]         prio;
    logic signed [9:0]  y;
    logic signed [10:0] x;
    logic [7:0]         index;
  } sprite_cmd_t;

  // Result item as it sits on m_axis_tdata, highest field first.
  typedef struct packed {
    logic [3:0]         pad;
    logic               opaque;
    logic [2:0]         palette;
    logic [1:0]         mirror;
    logic [9:0]         image;
    logic [6:0]         height;
    logic [3:0]         prio;
    logic signed [9:0]  y;
    logic signed [10:0] x;
    logic [3:0]         number;
  } slot_report_t;

  typedef struct packed {
    logic         last;
    slot_report_t rep;
  } line_result_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    sprite_cmd_t        cmd;
  } pending_item_t;

  // Shadow copies of what the block holds.
  typedef struct packed {
    logic signed [10:0] x;
    logic signed [9:0]  y;
    logic [3:0]         prio;
    logic [1:0]         mirror;
    logic               opaque;
    logic [9:0]         image;
    logic [2:0]         hcode;
    logic [2:0]         palette;
  } sprite_attr_t;

  typedef struct packed {
    logic signed [10:0] x;
    logic signed [9:0]  y;
    logic [3:0]         prio;
    logic [6:0]         height;
    logic [9:0]         image;
    logic [1:0]         mirror;
    logic [2:0]         palette;
    logic               opaque;
  } slot_state_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [ActionW-1:0]  s_axis_tuser  = ACT_WRITE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  sprite_slot_refill i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Line predictor. It mirrors the table, the slots and the table pointer and
  // is advanced once per item accepted on the input side.
  // ---------------------------------------------------------------------------
  sprite_attr_t  sprite_attr_tbl [ENTRIES];
  slot_state_t   slot_regs [SLOTS];
  int unsigned   entry_ptr;
  line_result_t  slot_reports_due [$];
  int unsigned   mismatch_cnt;

  // Refill one slot from the next table entry. A slot with no entry left, or
  // whose sprite sits wholly left or right of the screen, is parked below the
  // last line with zero height; an exhausted table leaves its other fields.
  function automatic void load_slot(int s);
    sprite_attr_t e;
    if (entry_ptr < ENTRIES) begin
      e = sprite_attr_tbl[entry_ptr];
      entry_ptr++;
      slot_regs[s].x       = e.x;
      slot_regs[s].y       = e.y;
      slot_regs[s].prio    = e.prio;
      slot_regs[s].height  = 7'(8 * (int'(e.hcode) + 1));
      slot_regs[s].image   = e.image;
      slot_regs[s].mirror  = e.mirror;
      slot_regs[s].palette = e.palette;
      slot_regs[s].opaque  = e.opaque;
      if (int'(e.x) <= -int'(SPAN) || int'(e.x) >= int'(SCR_W)) begin
        slot_regs[s].y      = 10'(SCR_H);
        slot_regs[s].height = '0;
      end
    end else begin
      slot_regs[s].y      = 10'(SCR_H);
      slot_regs[s].height = '0;
    end
  endfunction

  // Refill pass in slot order, then the emission order: priority buckets
  // from low to high, and within a bucket the highest slot first. Every slot
  // lands in some bucket, so each line yields exactly SLOTS results.
  function automatic void predict_line(logic [8:0] line);
    line_result_t r;
    int           emitted;
    emitted = 0;
    for (int s = 0; s < int'(SLOTS); s++) begin
      if (int'(line) >= int'(slot_regs[s].y) + int'(slot_regs[s].height)) begin
        load_slot(s);
      end
    end
    for (int p = 0; p < int'(PRIO_LEVELS); p++) begin
      for (int s = int'(SLOTS) - 1; s >= 0; s--) begin
        if (int'(slot_regs[s].prio) != p) continue;
        r.rep.pad     = '0;
        r.rep.number  = 4'(s);
        r.rep.x       = slot_regs[s].x;
        r.rep.y       = slot_regs[s].y;
        r.rep.prio    = slot_regs[s].prio;
        r.rep.height  = slot_regs[s].height;
        r.rep.image   = slot_regs[s].image;
        r.rep.mirror  = slot_regs[s].mirror;
        r.rep.palette = slot_regs[s].palette;
        r.rep.opaque  = slot_regs[s].opaque;
        r.last        = (emitted == int'(SLOTS) - 1);
        slot_reports_due.push_back(r);
        emitted++;
      end
    end
  endfunction

  function automatic void apply_item(logic [ActionW-1:0] act, sprite_cmd_t cmd);
    sprite_attr_t e;
    case (act)
      ACT_WRITE: begin
        if (int'(cmd.index) < int'(ENTRIES)) begin
          e.x       = cmd.x;
          e.y       = cmd.y;
          // Priorities beyond the last bucket are clamped on load.
          e.prio    = (int'(cmd.prio) >= int'(PRIO_LEVELS)) ? 4'(PRIO_LEVELS - 1) : cmd.prio;
          e.mirror  = cmd.mirror;
          e.opaque  = cmd.opaque;
          e.image   = cmd.image;
          e.hcode   = cmd.hcode;
          e.palette = cmd.palette;
          sprite_attr_tbl[cmd.index] = e;
        end
      end
      ACT_FRAME: begin
        // A cleared slot is all zero, priority included.
        for (int s = 0; s < int'(SLOTS); s++) slot_regs[s] = '0;
        entry_ptr = 0;
      end
      ACT_LINE: predict_line(cmd.line);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  initial begin
    for (int s = 0; s < int'(SLOTS); s++) slot_regs[s] = '0;
    for (int i = 0; i < int'(ENTRIES); i++) sprite_attr_tbl[i] = '0;
    entry_ptr    = 0;
    mismatch_cnt = 0;
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // feeds each accepted input item to the predictor. Both handshakes are
  // sampled at the rising edge, before any register behind them updates.
  always @(posedge clk_i) begin
    line_result_t want;
    slot_report_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (slot_reports_due.size() == 0) begin
          $error("result for slot %0d arrived with nothing outstanding", got.number);
          mismatch_cnt++;
        end else begin
          want = slot_reports_due.pop_front();
          check_field("slot_number",   want.rep.number,  got.number);
          check_field("slot_x",        want.rep.x,       got.x);
          check_field("slot_y",        want.rep.y,       got.y);
          check_field("slot_priority", want.rep.prio,    got.prio);
          check_field("slot_height",   want.rep.height,  got.height);
          check_field("slot_image",    want.rep.image,   got.image);
          check_field("slot_mirror",   want.rep.mirror,  got.mirror);
          check_field("slot_palette",  want.rep.palette, got.palette);
          check_field("slot_opaque",   want.rep.opaque,  got.opaque);
          check_field("last",          want.last,        m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Items are built up front into a queue that the driver drains.
  // A line item reads up to SLOTS table entries past the pointer, and reading
  // a never written entry is not allowed, so the builder keeps an upper bound
  // on the pointer since the last frame start and writes any entry in the
  // next window that has not been written yet before it issues the line.
  // ---------------------------------------------------------------------------
  pending_item_t sprite_items [$];
  bit            entry_loaded [ENTRIES];
  int unsigned   ptr_bound;

  function automatic sprite_cmd_t random_sprite();
    sprite_cmd_t c;
    c = sprite_cmd_t'({$urandom(), $urandom()});
    c.pad = '0;
    case ($urandom_range(0, 9))
      0:       c.x = 11'($urandom_range(0, 1) ? -1024 : 1023);
      1:       c.x = 11'($urandom());
      2:       c.x = 11'($urandom_range(0, 1) ? -int'(SPAN) : int'(SCR_W));
      default: c.x = 11'(int'($urandom_range(0, SCR_W + SPAN - 2)) - int'(SPAN) + 1);
    endcase
    case ($urandom_range(0, 7))
      0:       c.y = 10'($urandom());
      1:       c.y = 10'($urandom_range(0, 1) ? -512 : 511);
      default: c.y = 10'(int'($urandom_range(0, SCR_H + 40)) - 40);
    endcase
    // Few buckets in use keep most lines short; all sixteen appear as well.
    if ($urandom_range(0, 2) != 0) c.prio = 4'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic void queue_item(logic [ActionW-1:0] act, sprite_cmd_t c);
    pending_item_t it;
    it.action = act;
    it.cmd    = c;
    sprite_items.push_back(it);
  endfunction

  function automatic void queue_write(int idx, sprite_cmd_t c);
    c.index = 8'(idx);
    entry_loaded[idx] = 1'b1;
    queue_item(ACT_WRITE, c);
  endfunction

  function automatic void queue_frame();
    ptr_bound = 0;
    queue_item(ACT_FRAME, random_sprite());
  endfunction

  function automatic void queue_line(int line);
    sprite_cmd_t c;
    int unsigned top;
    top = (ptr_bound + SLOTS > ENTRIES) ? ENTRIES : ptr_bound + SLOTS;
    for (int unsigned i = ptr_bound; i < top; i++) begin
      if (!entry_loaded[i]) queue_write(int'(i), random_sprite());
    end
    ptr_bound = top;
    c      = random_sprite();
    c.line = 9'(line);
    queue_item(ACT_LINE, c);
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7:       return int'($urandom_range(1, 4));
      8:             return int'($urandom_range(5, 20));
      default:       return int'($urandom_range(20, 60));
    endcase
  endfunction

  function automatic void build_stimulus();
    sprite_cmd_t c;
    int          line;
    int          lines;
    // Reset leaves the pointer at zero, just as a frame start does.
    ptr_bound = 0;
    for (int i = 0; i < int'(ENTRIES); i++) entry_loaded[i] = 1'b0;

    // Directed part: a frame start, sixteen entries that cover the edges of
    // the horizontal window and the field extremes, the top table index, an
    // item with the unused action, and a first line that refills every slot.
    queue_frame();
    for (int i = 0; i < int'(SLOTS); i++) begin
      c = random_sprite();
      c.x = 11'(int'($urandom_range(0, 200)));
      case (i)
        0: c.x = 11'(-1024);
        1: c.x = 11'sd1023;
        2: c.x = 11'(-int'(SPAN));          // just off the left edge
        3: c.x = 11'(1 - int'(SPAN));       // last column still visible
        4: c.x = 11'(int'(SCR_W) - 1);      // rightmost visible column
        5: c.x = 11'(SCR_W);                // just off the right edge
        6: c.y = 10'(-512);
        7: c.y = 10'sd511;
        8: begin
          c.prio    = 4'hF;
          c.image   = 10'h3FF;
          c.hcode   = 3'd7;
          c.palette = 3'd7;
          c.mirror  = 2'd3;
          c.opaque  = 1'b1;
        end
        9: begin
          c.x       = '0;
          c.y       = '0;
          c.prio    = '0;
          c.image   = '0;
          c.hcode   = '0;
          c.palette = '0;
          c.mirror  = '0;
          c.opaque  = 1'b0;
        end
        default: ;
      endcase
      queue_write(i, c);
    end
    queue_write(int'(ENTRIES) - 1, random_sprite());
    queue_item(ACT_SPARE, random_sprite());
    queue_line(0);

    // Random part: mostly whole frames with rising scan lines, mixed with
    // stray lines, rewrites of random entries and ignored items.
    while (sprite_items.size() < 520) begin
      case ($urandom_range(0, 19))
        0: queue_item(ACT_SPARE, random_sprite());
        1, 2: queue_write(int'($urandom_range(0, ENTRIES - 1)), random_sprite());
        3: queue_line(int'($urandom_range(0, 511)));
        4: begin
          // Run the table dry: line 511 retires nearly every slot each time.
          queue_frame();
          lines = int'($urandom_range(16, 20));
          for (int n = 0; n < lines; n++) queue_line(511);
        end
        default: begin
          // Now and then the frame start is left out on purpose.
          if ($urandom_range(0, 7) != 0) queue_frame();
          lines = int'($urandom_range(1, 24));
          line  = int'($urandom_range(0, 40));
          for (int n = 0; n < lines; n++) begin
            if ($urandom_range(0, 11) == 0) begin
              queue_write(int'($urandom_range(0, ENTRIES - 1)), random_sprite());
            end
            queue_line(line);
            case ($urandom_range(0, 14))
              0:       line = 511;
              1:       line = int'($urandom_range(0, 511));
              default: line = line + int'($urandom_range(1, 20));
            endcase
            if (line > 511) line = 511;
          end
        end
      endcase
    end
  endfunction

  // Driver: presents queued items in bursts of random length separated by
  // random gaps. A presented item stays put until the block takes it.
  int send_gap   = 0;
  int burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pending_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sprite_items.size() != 0) begin
        nxt = sprite_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.action;
        s_axis_tdata  <= nxt.cmd;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = int'($urandom_range(1, 24));
          send_gap   = pick_gap();
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, random, sparse and alternating
  // patterns. Once, after enough results, it holds off for a long stretch so
  // that the block stalls on its output and then refuses input.
  int unsigned results_taken = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned rx_mode       = 0;
  int unsigned mode_left     = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_taken++;
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 5) == 0);
          default: rdy = !m_axis_tready;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Main sequence: build the items, release reset, wait until every item has
  // been taken and every predicted result has arrived, idle a little longer
  // to catch stray results, then report.
  initial begin
    build_stimulus();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sprite_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (slot_reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** sprite_slot_refill: PASSED **");
    end else begin
      $display("** sprite_slot_refill: FAILED **");
    end
    $finish;
  end

  // Watchdog, with a wide margin over the slowest correct run. That run is
  // bounded by the number of items, the slot walk of each line inside the
  // block once per priority in use, the results held by the slowest receiver
  // pattern, the sender gaps and one long hold-off.
  initial begin
    #30ms;
    $display("** sprite_slot_refill: FAILED **");
    $finish;
  end

endmodule
